[design/dsit_pkg.sv]
// ----------------------------------------------------------------------------
// dsit_pkg
// shared types and codes for the descending sorted insert table
// ----------------------------------------------------------------------------
package dsit_pkg;

  localparam int KIND_W   = 2;
  localparam int SCORE_W  = 32;
  localparam int LINES_W  = 16;
  localparam int LEVEL_W  = 16;
  localparam int RIDX_W   = 4;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;

  // operation codes
  localparam logic [KIND_W-1:0] OP_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] OP_APPEND = 2'd1;
  localparam logic [KIND_W-1:0] OP_CLEAR  = 2'd2;
  localparam logic [KIND_W-1:0] OP_READ   = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd3;

  // score in the top bits, so a plain unsigned compare ranks records
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [LINES_W-1:0] lines;
    logic [LEVEL_W-1:0] level;
  } rec_t;

endpackage

[design/dsit_if.sv]
// ----------------------------------------------------------------------------
// dsit_if
// request and response channels of the descending sorted insert table
// ----------------------------------------------------------------------------
interface dsit_req_if;
  import dsit_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [SCORE_W-1:0] score_in;
  logic [LINES_W-1:0] lines_in;
  logic [LEVEL_W-1:0] level_in;
  logic [RIDX_W-1:0]  read_index;

  modport source (output valid, kind, score_in, lines_in, level_in, read_index,
                  input ready);
  modport sink   (input valid, kind, score_in, lines_in, level_in, read_index,
                  output ready);
endinterface

interface dsit_rsp_if;
  import dsit_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    position;
  logic [SCORE_W-1:0]  score_out;
  logic [LINES_W-1:0]  lines_out;
  logic [LEVEL_W-1:0]  level_out;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, status, position, score_out, lines_out, level_out,
                  entry_count, input ready);
  modport sink   (input valid, status, position, score_out, lines_out, level_out,
                  entry_count, output ready);
endinterface

[design/descending_sorted_insert_table.sv]
// ----------------------------------------------------------------------------
// descending_sorted_insert_table
// bounded record table kept in descending order of score, lines, level
// ----------------------------------------------------------------------------
// usage
//   req carries one request: kind selects sorted add, append, clear or read;
//   score_in, lines_in and level_in give the record, read_index the entry.
//   rsp returns exactly one response per request: status, position, the
//   record read (zero for other kinds) and the entry count after the request.
//   both channels use valid/ready; a transfer happens when both are high.
// operation
//   one request is in flight at a time; req.ready is high while idle.
//   clear, append and full rejects go from decode straight to emit; a read
//   first waits for the registered read data. a sorted add walks the table
//   and reads one entry per cycle through the single read port (scan down
//   to the insert point, then shift the tail up one slot); a duplicate ends
//   the scan at its entry. the next request is taken once back in idle.
// reset
//   rst clears the entry count and control state and holds req.ready low;
//   record contents are kept, entries beyond the count are never returned.
// stalls
//   the response sits in an output register until rsp.ready; a new request
//   may be accepted and worked meanwhile, and waits for the register to free.
// ----------------------------------------------------------------------------
module descending_sorted_insert_table #(
  parameter int TABLE_DEPTH = 16
) (
  input logic   clk,
  input logic   rst,
  dsit_req_if.sink   req,
  dsit_rsp_if.source rsp
);
  import dsit_pkg::*;

  localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int CMPW = (CW > RIDX_W) ? CW : RIDX_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_WRNEW  = 3'd4;
  localparam logic [2:0] S_RDWAIT = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0]        state;
  logic [CW-1:0]     occupied;

  // latched request
  logic [KIND_W-1:0] req_kind;
  rec_t              req_rec;
  logic [RIDX_W-1:0] req_ridx;

  // walk pointers
  logic [IW-1:0]     scan_p;
  logic [IW-1:0]     shift_k;

  // pending response
  logic [STATUS_W-1:0] res_status;
  logic [POS_W-1:0]    res_pos;
  rec_t                res_rec;

  // output register
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [POS_W-1:0]    out_pos;
  rec_t                out_rec;
  logic [COUNT_W-1:0]  out_count;

  // memory port
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  rec_t          rd_data;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  rec_t          wr_data;

  logic          full;
  logic          empty;
  logic          read_hit;
  logic          rank_gt;
  logic          rank_eq;
  logic          scan_last;
  logic [IW-1:0] occ_idx;
  logic [IW-1:0] occ_last;
  logic [IW-1:0] k_minus1;

  assign full      = (occupied == CW'(TABLE_DEPTH));
  assign empty     = (occupied == '0);
  assign read_hit  = (CMPW'(req_ridx) < CMPW'(occupied)) &&
                     (CMPW'(req_ridx) < CMPW'(TABLE_DEPTH));
  // stored entry against new record: above, equal or below
  assign rank_gt   = (rd_data > req_rec);
  assign rank_eq   = (rd_data == req_rec);
  assign scan_last = ((CW'(scan_p) + CW'(1)) == occupied);
  assign occ_idx   = IW'(occupied);
  assign occ_last  = IW'(occupied - CW'(1));
  assign k_minus1  = shift_k - IW'(1);

  dsit_mem #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (IW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // memory accesses per state
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = req_rec;
    case (state)
      S_DECODE: begin
        case (req_kind)
          OP_APPEND: begin
            wr_en   = !full;
            wr_addr = occ_idx;
          end
          OP_READ: begin
            rd_en   = read_hit;
            rd_addr = IW'(req_ridx);
          end
          OP_CLEAR: begin
            rd_en = 1'b0;
          end
          default: begin
            // sorted add: empty table takes slot 0, else start the walk
            wr_en   = !full && empty;
            rd_en   = !full && !empty;
          end
        endcase
      end
      S_SCAN: begin
        if (rank_gt) begin
          if (scan_last) begin
            wr_en   = 1'b1;
            wr_addr = occ_idx;
          end else begin
            rd_en   = 1'b1;
            rd_addr = scan_p + IW'(1);
          end
        end else if (!rank_eq) begin
          rd_en   = 1'b1;
          rd_addr = occ_last;
        end
      end
      S_SHIFT: begin
        // move entry k-1 up to k, fetch the next one down
        wr_en   = 1'b1;
        wr_addr = shift_k;
        wr_data = rd_data;
        if (k_minus1 != scan_p) begin
          rd_en   = 1'b1;
          rd_addr = k_minus1 - IW'(1);
        end
      end
      S_WRNEW: begin
        wr_en   = 1'b1;
        wr_addr = scan_p;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occupied  <= '0;
      out_valid <= 1'b0;
    end else begin
      // the emit state reloads the register itself
      if (out_valid && rsp.ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            req_kind      <= req.kind;
            req_rec.score <= req.score_in;
            req_rec.lines <= req.lines_in;
            req_rec.level <= req.level_in;
            req_ridx      <= req.read_index;
            state         <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_rec <= '0;
          case (req_kind)
            OP_CLEAR: begin
              occupied   <= '0;
              res_status <= ST_DONE;
              res_pos    <= '0;
              state      <= S_EMIT;
            end
            OP_APPEND: begin
              state <= S_EMIT;
              if (full) begin
                res_status <= ST_FULL;
                res_pos    <= '0;
              end else begin
                res_status <= ST_DONE;
                res_pos    <= POS_W'(occupied);
                occupied   <= occupied + CW'(1);
              end
            end
            OP_READ: begin
              res_pos <= req_ridx;
              if (read_hit) begin
                res_status <= ST_DONE;
                state      <= S_RDWAIT;
              end else begin
                res_status <= ST_MISS;
                state      <= S_EMIT;
              end
            end
            default: begin
              res_pos <= '0;
              if (full) begin
                res_status <= ST_FULL;
                state      <= S_EMIT;
              end else if (empty) begin
                res_status <= ST_DONE;
                occupied   <= CW'(1);
                state      <= S_EMIT;
              end else begin
                res_status <= ST_DONE;
                scan_p     <= '0;
                state      <= S_SCAN;
              end
            end
          endcase
        end
        S_SCAN: begin
          if (rank_gt) begin
            if (scan_last) begin
              // lands after every stored entry
              res_pos  <= POS_W'(occupied);
              occupied <= occupied + CW'(1);
              state    <= S_EMIT;
            end else begin
              scan_p <= scan_p + IW'(1);
            end
          end else if (rank_eq) begin
            res_status <= ST_DUP;
            state      <= S_EMIT;
          end else begin
            shift_k <= occ_idx;
            state   <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (k_minus1 == scan_p) begin
            state <= S_WRNEW;
          end else begin
            shift_k <= k_minus1;
          end
        end
        S_WRNEW: begin
          res_pos  <= POS_W'(scan_p);
          occupied <= occupied + CW'(1);
          state    <= S_EMIT;
        end
        S_RDWAIT: begin
          res_rec <= rd_data;
          state   <= S_EMIT;
        end
        S_EMIT: begin
          // hand over once the output register is free
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_pos    <= res_pos;
            out_rec    <= res_rec;
            out_count  <= COUNT_W'(occupied);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready       = (state == S_IDLE) && !rst;
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.position    = out_pos;
  assign rsp.score_out   = out_rec.score;
  assign rsp.lines_out   = out_rec.lines;
  assign rsp.level_out   = out_rec.level;
  assign rsp.entry_count = out_count;

  // no read and write of the same slot in one cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write hit the same slot");

  // count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMPW'(occupied) <= CMPW'(TABLE_DEPTH))
    else $error("entry count beyond table size");

  // the shift pointer stays above the insert point
  a_shift_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (shift_k > scan_p))
    else $error("shift pointer at or below insert point");

  // an accepted request is decoded on the next cycle
  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == S_DECODE))
    else $error("accepted request not decoded");

endmodule

[design/dsit_mem.sv]
// ----------------------------------------------------------------------------
// dsit_mem
// record store, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module dsit_mem #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output dsit_pkg::rec_t    rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  dsit_pkg::rec_t    wr_data
);
  import dsit_pkg::*;

  rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
